// ===== src/bmhq_pkg.sv =====
`timescale 1ns / 1ps

package bmhq_pkg;

    // fixed field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load_req;      // capture input beat
        logic start_insert;  // grow count, hole at new end
        logic start_remove;  // shrink count, read root and last entry
        logic set_empty_err;
        logic set_full_err;
        logic rd_parent;     // read parent of hole
        logic up_step;       // move parent down into hole
        logic up_done;       // place held value into hole (sift up)
        logic rm_load;       // take root and last entry from read data
        logic rd_children;   // read both children of hole
        logic dn_step;       // move chosen child up into hole
        logic dn_done;       // place held value into hole (sift down)
        logic out_load;      // present result beat
    } bmhq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic req_remove;
        logic empty;
        logic full;
        logic at_root;
        logic leaf;
        logic up_move;
        logic dn_move;
        logic count_zero;
        logic out_free;
    } bmhq_stat_t;

endpackage

// ===== src/bmhq_ram.sv =====
`timescale 1ns / 1ps

module bmhq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== src/bmhq_ctrl.sv =====
`timescale 1ns / 1ps

module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  bmhq_stat_t stat,
    output bmhq_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_UP_RD   = 4'd2;
    localparam logic [3:0] S_UP_CMP  = 4'd3;
    localparam logic [3:0] S_RM_WAIT = 4'd4;
    localparam logic [3:0] S_DN_RD   = 4'd5;
    localparam logic [3:0] S_DN_CMP  = 4'd6;
    localparam logic [3:0] S_OUT     = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.req_remove) begin
                    if (stat.empty) begin
                        cmd.set_empty_err = 1'b1;
                        state_next        = S_OUT;
                    end else begin
                        cmd.start_remove = 1'b1;
                        state_next       = S_RM_WAIT;
                    end
                end else begin
                    if (stat.full) begin
                        cmd.set_full_err = 1'b1;
                        state_next       = S_OUT;
                    end else begin
                        cmd.start_insert = 1'b1;
                        state_next       = S_UP_RD;
                    end
                end
            end
            S_UP_RD: begin
                if (stat.at_root) begin
                    cmd.up_done = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (stat.up_move) begin
                    cmd.up_step = 1'b1;
                    state_next  = S_UP_RD;
                end else begin
                    cmd.up_done = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_RM_WAIT: begin
                cmd.rm_load = 1'b1;
                state_next  = stat.count_zero ? S_OUT : S_DN_RD;
            end
            S_DN_RD: begin
                if (stat.leaf) begin
                    cmd.dn_done = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    cmd.rd_children = 1'b1;
                    state_next      = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (stat.dn_move) begin
                    cmd.dn_step = 1'b1;
                    state_next  = S_DN_RD;
                end else begin
                    cmd.dn_done = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bmhq_dp.sv =====
`timescale 1ns / 1ps

module bmhq_dp
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bmhq_cmd_t           cmd,
    output bmhq_stat_t          stat,
    input  logic                req_type,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VALUE_W-1:0]  out_max_value,
    output logic [STATUS_W-1:0] out_status,
    output logic [COUNT_W-1:0]  out_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 1;

    logic                req_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       pos_reg;
    logic [VALUE_W-1:0]  cur_reg;
    logic [VALUE_W-1:0]  maxv_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_max_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [VALUE_W-1:0]  wdata;
    logic [AW-1:0]       raddr_a;
    logic [AW-1:0]       raddr_b;
    logic [VALUE_W-1:0]  rdata_a;
    logic [VALUE_W-1:0]  rdata_b;

    logic [PW-1:0]       left_pos;
    logic [PW-1:0]       right_pos;
    logic [PW-1:0]       count_ext;
    logic [CW-1:0]       count_inc;
    logic [CW-1:0]       count_dec;
    logic                has_right;
    logic                pick_right;
    logic [VALUE_W-1:0]  child;
    logic [CW-1:0]       pick_pos;

    bmhq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY),
        .ADDR_W(AW)
    ) u_ram (
        .aclk   (aclk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b)
    );

    // position arithmetic, heap entry k lives at slot k-1
    assign left_pos  = {pos_reg, 1'b0};
    assign right_pos = {pos_reg, 1'b1};
    assign count_ext = PW'(count_reg);
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    // child selection, right wins a tie
    assign has_right  = (right_pos <= count_ext);
    assign pick_right = has_right && !($signed(rdata_a) > $signed(rdata_b));
    assign child      = pick_right ? rdata_b : rdata_a;
    assign pick_pos   = pick_right ? right_pos[CW-1:0] : left_pos[CW-1:0];

    // memory read addresses
    always_comb begin
        raddr_a = '0;
        raddr_b = AW'(count_dec);
        if (cmd.start_remove) begin
            raddr_a = '0;
            raddr_b = AW'(count_dec);
        end else if (cmd.rd_parent) begin
            raddr_a = AW'(CW'(pos_reg >> 1) - 1'b1);
        end else if (cmd.rd_children) begin
            raddr_a = AW'(left_pos - 1'b1);
            raddr_b = AW'(left_pos);
        end
    end

    // memory write into the hole
    assign we    = cmd.up_step | cmd.up_done | cmd.dn_step | cmd.dn_done;
    assign waddr = AW'(pos_reg - 1'b1);
    always_comb begin
        if (cmd.up_step) begin
            wdata = rdata_a;
        end else if (cmd.dn_step) begin
            wdata = child;
        end else begin
            wdata = cur_reg;
        end
    end

    // status to controller
    assign stat.req_remove = (req_reg == REQ_REMOVE);
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(CAPACITY));
    assign stat.at_root    = (pos_reg == CW'(1));
    assign stat.leaf       = (left_pos > count_ext);
    assign stat.up_move    = ($signed(cur_reg) > $signed(rdata_a));
    assign stat.dn_move    = ($signed(child) > $signed(cur_reg));
    assign stat.count_zero = (count_reg == '0);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // request and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg    <= req_type;
            value_reg  <= value;
            maxv_reg   <= '0;
            status_reg <= ST_OK;
        end
        if (cmd.set_empty_err) begin
            status_reg <= ST_EMPTY;
        end
        if (cmd.set_full_err) begin
            status_reg <= ST_FULL;
        end
        if (cmd.start_insert) begin
            pos_reg <= count_inc;
            cur_reg <= value_reg;
        end
        if (cmd.up_step) begin
            pos_reg <= CW'(pos_reg >> 1);
        end
        if (cmd.rm_load) begin
            maxv_reg <= rdata_a;
            cur_reg  <= rdata_b;
            pos_reg  <= CW'(1);
        end
        if (cmd.dn_step) begin
            pos_reg <= pick_pos;
        end
    end

    // entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.start_insert) begin
            count_reg <= count_inc;
        end else if (cmd.start_remove) begin
            count_reg <= count_dec;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_max_reg    <= maxv_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(count_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_max_value = out_max_reg;
    assign out_status    = out_status_reg;
    assign out_count     = out_count_reg;

endmodule

// ===== src/binary_max_heap_queue.sv =====
`timescale 1ns / 1ps

// Max-priority queue of signed 32-bit values kept as a binary heap in one
// dual-read, single-write RAM of CAPACITY entries. Each input beat either
// inserts a value or removes the maximum, and yields exactly one output
// beat with the removed value, a status code and the count after the
// request. Items are processed one at a time: an insert places the value
// at the new end and lets it climb toward the root, and a remove takes the
// root and lets the last entry sink toward a leaf. Each level moved takes a
// RAM read and then a compare-and-write, as the RAM read is registered.
// Errors (remove from empty, insert into full) go straight to the output.
// A new beat is accepted while the previous result still waits on the
// output; a finished result waits for that one to be taken before it is
// presented. The RAM needs no clearing after reset: only entries below the
// count are ever used.
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // max_value[31:0], count[42:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    bmhq_cmd_t           cmd;
    bmhq_stat_t          stat;
    logic [VALUE_W-1:0]  max_value;
    logic [COUNT_W-1:0]  count;

    bmhq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bmhq_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (s_tuser[0]),
        .value        (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_max_value(max_value),
        .out_status   (m_tuser),
        .out_count    (count)
    );

    // pack result beat
    assign m_tdata = {5'd0, count, max_value};

endmodule

// ===== test/tb_binary_max_heap_queue.sv =====
`timescale 1ns / 1ps

module tb_binary_max_heap_queue;
    import bmhq_pkg::*;

    localparam int HEAP_DEPTH   = 1024;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 40;

    // expected result of one request
    typedef struct {
        logic signed [VALUE_W-1:0]  max_value;
        logic        [STATUS_W-1:0] status;
        logic        [COUNT_W-1:0]  count;
    } heap_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // value[31:0]
    logic [0:0]  s_tuser  = '0;   // req_type[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // max_value[31:0], count[42:32], zero pad
    logic [1:0]  m_tuser;         // status[1:0]

    // shadow heap, one-based like the block's layout
    logic signed [VALUE_W-1:0] heap_mem [1:HEAP_DEPTH];
    int                        held = 0;

    heap_result_t pending_results[$];

    bit idle_en = 1'b1;
    bit hold_on = 1'b0;
    int mismatches = 0;
    int cycle_cnt  = 0;
    int n_inserts = 0, n_removes = 0, n_beats = 0, n_empty = 0, n_full = 0;
    int peak_held = 0;

    binary_max_heap_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    // applies one request to the shadow heap and returns the beat it should yield
    function automatic heap_result_t heap_apply(logic req, logic signed [VALUE_W-1:0] v);
        heap_result_t              r;
        int                        pos;
        int                        kid;
        logic signed [VALUE_W-1:0] tmp;
        r.max_value = '0;
        r.status    = ST_OK;
        if (req == REQ_INSERT) begin
            if (held >= HEAP_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                held++;
                heap_mem[held] = v;
                pos = held;
                // sift up while strictly greater than the parent
                while (pos > 1 && heap_mem[pos] > heap_mem[pos / 2]) begin
                    tmp                = heap_mem[pos / 2];
                    heap_mem[pos / 2]  = heap_mem[pos];
                    heap_mem[pos]      = tmp;
                    pos                = pos / 2;
                end
            end
        end else if (held == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.max_value = heap_mem[1];
            heap_mem[1] = heap_mem[held];
            held--;
            pos = 1;
            // sift down, right child wins a tie
            while (2 * pos <= held) begin
                kid = 2 * pos;
                if (kid + 1 <= held && !(heap_mem[kid] > heap_mem[kid + 1]))
                    kid++;
                if (!(heap_mem[kid] > heap_mem[pos]))
                    break;
                tmp           = heap_mem[pos];
                heap_mem[pos] = heap_mem[kid];
                heap_mem[kid] = tmp;
                pos           = kid;
            end
        end
        if (held > peak_held)
            peak_held = held;
        r.count = COUNT_W'(held);
        return r;
    endfunction

    // random value with extremes and a narrow band for ties
    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom_range(8) - 4;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // one input beat, with an occasional gap in front of it
    task automatic send_request(logic req, logic [31:0] v);
        int gap;
        if (idle_en && $urandom_range(99) < 22) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(heap_apply(req, v));
        if (req == REQ_INSERT)
            n_inserts++;
        else
            n_removes++;
    endtask

    // sender pauses until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_request(REQ_REMOVE, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h8000_0000);
        send_request(REQ_INSERT, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h0000_0000);
        // equal keys exercise the tie rules both ways
        repeat (3) send_request(REQ_INSERT, 32'd5);
        send_request(REQ_INSERT, 32'd1);
        send_request(REQ_INSERT, 32'h5555_5555);
        send_request(REQ_INSERT, 32'hAAAA_AAAA);
        repeat (11) send_request(REQ_REMOVE, $urandom());
        send_request(REQ_REMOVE, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    // small heap, frequent empty removes and last-entry removes
    task automatic test_mixed(int n);
        repeat (n) begin
            if ($urandom_range(99) < 50)
                send_request(REQ_INSERT, pick_value());
            else
                send_request(REQ_REMOVE, $urandom());
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_on <= 1'b0;
            end
        join_none
        repeat (24) begin
            if ($urandom_range(99) < 65)
                send_request(REQ_INSERT, pick_value());
            else
                send_request(REQ_REMOVE, $urandom());
        end
        wait_drained();
    endtask

    // pure inserts up to capacity, first part without any idling
    task automatic test_fill_to_full();
        int k;
        k = 0;
        idle_en = 1'b0;
        while (held < HEAP_DEPTH) begin
            if (k == 300)
                idle_en = 1'b1;
            send_request(REQ_INSERT, pick_value());
            k++;
        end
        idle_en = 1'b1;
    endtask

    // hover around the full mark
    task automatic test_full_band(int n);
        repeat (n) begin
            if (held >= HEAP_DEPTH && $urandom_range(99) < 50)
                send_request(REQ_REMOVE, $urandom());
            else
                send_request(REQ_INSERT, pick_value());
        end
    endtask

    // mostly removes, the heap should hand back values in order
    task automatic test_drain(int n);
        repeat (n) begin
            if ($urandom_range(99) < 90)
                send_request(REQ_REMOVE, $urandom());
            else
                send_request(REQ_INSERT, pick_value());
        end
    endtask

    // result check and receiver readiness
    always @(posedge aclk) begin
        heap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_beats++;
            if (pending_results.size() == 0) begin
                report_mismatch("beat with no request", $signed(m_tdata[31:0]), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.max_value)
                    report_mismatch("max_value", $signed(m_tdata[31:0]), want.max_value);
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[42:32] !== want.count)
                    report_mismatch("count", m_tdata[42:32], want.count);
                if (want.status == ST_EMPTY)
                    n_empty++;
                if (want.status == ST_FULL)
                    n_full++;
            end
        end
        if (hold_on)
            m_tready <= 1'b0;
        else if (idle_en)
            m_tready <= ($urandom_range(99) >= 22);
        else
            m_tready <= 1'b1;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_mixed(150);
        test_backpressure();
        test_fill_to_full();
        test_full_band(40);
        test_drain(500);

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);

        $display("%0d requests (%0d inserts, %0d removes), %0d beats checked",
                 n_inserts + n_removes, n_inserts, n_removes, n_beats);
        $display("%0d removes from empty, %0d inserts into full, peak depth %0d of %0d",
                 n_empty, n_full, peak_held, HEAP_DEPTH);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
